[rtl/rwc_pkg.sv]
// Shared constants, types and register indexes of the RGB window convolution.
`default_nettype none
package rwc_pkg;
   localparam int KERNEL_SIDE = 3;
   localparam int TAP_N = KERNEL_SIDE * KERNEL_SIDE;
   localparam int CH_N = 3;
   localparam int PIX_W = 8;
   localparam int COEF_W = 16;
   localparam int PROD_W = PIX_W + 1 + COEF_W;
   localparam int SUM_W = PROD_W + 4;
   localparam int PIXEL_MAX = 255;
   localparam int GEOM_W = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int OUT_DEPTH = 8;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_COEF_FRAC_BITS = 8;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_TOP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_MIDDLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_BOTTOM = 3'd5;

   localparam logic [GEOM_W-1:0] RST_FRAME_WIDTH = 11'd640;
   localparam logic [GEOM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_MIDDLE = 48'h0000_0100_0000;

   typedef logic [CH_N*PIX_W-1:0] pixel_type;
   typedef logic [KERNEL_SIDE-1:0][KERNEL_SIDE-1:0][CH_N*PIX_W-1:0] window_type;
   typedef logic [TAP_N-1:0][PIX_W-1:0] tap_pix_type;
   typedef logic [TAP_N-1:0][COEF_W-1:0] tap_coef_type;
   typedef logic [CH_N-1:0][PIX_W-1:0] lane_values_type;

   typedef struct packed {
      logic valid;
      logic restart;
      logic drain;
      logic clear;
   } win_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic frame_end;
   } result_type;
endpackage
`default_nettype wire

[rtl/rwc_if.sv]
// Handshake interfaces of the request, response and register channels.
`default_nettype none
interface rwc_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source(output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink(input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface rwc_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic frame_end;
   modport source(output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink(input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rwc_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [47:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/rgb_window_convolution.sv]
// Top level of the 3x3 RGB window convolution over a raster pixel stream.
// Requests on req_ch carry one pixel (kind 0) or a drain marker (kind 1) in
// raster order. Each channel is filtered with a signed fixed-point 3x3 kernel,
// zero padded at the frame border, truncated and clamped to 0..255.
// Results on rsp_ch lag the input by one row plus one pixel; after the last
// pixel of a frame, width + 1 drain requests flush the remaining results.
// Drain requests that have nothing to flush are dropped without a response.
// Registers are written on csr_ch (always ready); a width or height write
// restarts the frame. Write registers only while the block is idle.
// Throughput: one request per cycle while req_ch.ready is high. A response
// passes the line store read, window shift, tap products and sum registers
// (clamp is combinational) before it is written into the output queue and
// offered on rsp_ch. An 8-entry output queue with credit control
// keeps taking requests while responses stall; req_ch.ready drops only when
// 8 responses are queued or in flight. Reset returns all registers to their
// defaults, clears the counters, window and queue; line stores are not
// cleared and need no clearing pass.
`default_nettype none
module rgb_window_convolution
   import rwc_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   rwc_req_if.sink req_ch,
   rwc_rsp_if.source rsp_ch,
   rwc_csr_if.sink csr_ch
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WVW = $clog2(MAX_WIDTH + 1);
   localparam int HVW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 3);

   function automatic logic [WVW-1:0] sat_w(input logic [GEOM_W-1:0] v);
      logic [WVW-1:0] r;
      if (v == '0) r = WVW'(1);
      else if (32'(v) > MAX_WIDTH) r = WVW'(MAX_WIDTH);
      else r = WVW'(v);
      return r;
   endfunction

   function automatic logic [HVW-1:0] sat_h(input logic [GEOM_W-1:0] v);
      logic [HVW-1:0] r;
      if (v == '0) r = HVW'(1);
      else if (32'(v) > MAX_HEIGHT) r = HVW'(MAX_HEIGHT);
      else r = HVW'(v);
      return r;
   endfunction

   logic [WVW-1:0] w_ff;
   logic [HVW-1:0] h_ff;
   logic radius_ff;
   logic [CSR_DATA_W-1:0] coef_ff [KERNEL_SIDE];

   logic [CW-1:0] in_col_ff, col0;
   logic [RW-1:0] in_row_ff, row0;
   logic [CW-1:0] out_col_ff, ocol0;
   logic [HVW-1:0] out_row_ff, orow0;

   logic accept, is_drain, restart_px, step, emit, primed, geom_wr, room, col_wrap;
   logic [KERNEL_SIDE-1:0] row_ok, col_ok;
   logic [TAP_N-1:0] mask0;
   logic frame_end0;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_fe_ff, s2_fe_ff, s3_fe_ff, s4_fe_ff;
   logic [TAP_N-1:0] s1_mask_ff, s2_mask_ff;

   win_req_type wreq;
   window_type window;
   tap_coef_type coefs;
   tap_pix_type taps [CH_N];
   lane_values_type lane_vals;

   assign csr_ch.ready = 1'b1;
   assign geom_wr = csr_ch.valid &&
                    (csr_ch.index == REG_FRAME_WIDTH || csr_ch.index == REG_FRAME_HEIGHT);
   assign req_ch.ready = room;
   assign accept = req_ch.valid && req_ch.ready;
   assign is_drain = req_ch.kind;
   assign restart_px = !is_drain && (32'(in_row_ff) >= 32'(h_ff));
   assign step = accept && (!is_drain ||
                 ((32'(in_row_ff) >= 32'(h_ff)) && (out_row_ff < h_ff)));

   assign col0 = restart_px ? '0 : in_col_ff;
   assign row0 = restart_px ? '0 : in_row_ff;
   assign ocol0 = restart_px ? '0 : out_col_ff;
   assign orow0 = restart_px ? '0 : out_row_ff;

   assign primed = (row0 >= RW'(2)) || (row0 == RW'(1) && col0 != '0);
   assign emit = step && primed && (orow0 < h_ff);
   assign col_wrap = (32'(col0) + 1) >= 32'(w_ff);

   assign row_ok[0] = orow0 != '0;
   assign row_ok[1] = 1'b1;
   assign row_ok[2] = (32'(orow0) + 1) < 32'(h_ff);
   assign col_ok[0] = ocol0 != '0;
   assign col_ok[1] = 1'b1;
   assign col_ok[2] = (32'(ocol0) + 1) < 32'(w_ff);

   always_comb begin
      for (int k = 0; k < KERNEL_SIDE; k++) begin
         for (int j = 0; j < KERNEL_SIDE; j++) begin
            mask0[k*KERNEL_SIDE+j] = row_ok[k] && col_ok[j] &&
                                     (radius_ff || (k == 1 && j == 1));
         end
      end
   end

   assign frame_end0 = (32'(orow0) + 1 == 32'(h_ff)) && (32'(ocol0) + 1 == 32'(w_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= sat_w(RST_FRAME_WIDTH);
         h_ff <= sat_h(RST_FRAME_HEIGHT);
         radius_ff <= 1'b1;
         coef_ff[0] <= '0;
         coef_ff[1] <= RST_COEF_MIDDLE;
         coef_ff[2] <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FRAME_WIDTH: w_ff <= sat_w(csr_ch.data[GEOM_W-1:0]);
            REG_FRAME_HEIGHT: h_ff <= sat_h(csr_ch.data[GEOM_W-1:0]);
            REG_KERNEL_RADIUS: radius_ff <= csr_ch.data[0];
            REG_COEF_TOP: coef_ff[0] <= csr_ch.data;
            REG_COEF_MIDDLE: coef_ff[1] <= csr_ch.data;
            REG_COEF_BOTTOM: coef_ff[2] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geom_wr) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (step) begin
         in_col_ff <= col_wrap ? '0 : col0 + 1'b1;
         in_row_ff <= col_wrap ? row0 + 1'b1 : row0;
         if (emit) begin
            if ((32'(ocol0) + 1) >= 32'(w_ff)) begin
               out_col_ff <= '0;
               out_row_ff <= orow0 + 1'b1;
            end else begin
               out_col_ff <= ocol0 + 1'b1;
               out_row_ff <= orow0;
            end
         end else begin
            out_col_ff <= ocol0;
            out_row_ff <= orow0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= emit;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s1_fe_ff <= frame_end0;
      s2_fe_ff <= s1_fe_ff;
      s3_fe_ff <= s2_fe_ff;
      s4_fe_ff <= s3_fe_ff;
      s1_mask_ff <= mask0;
      s2_mask_ff <= s1_mask_ff;
   end

   assign wreq.valid = step;
   assign wreq.restart = restart_px;
   assign wreq.drain = is_drain;
   assign wreq.clear = geom_wr;

   rwc_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock(clock),
      .reset(reset),
      .wreq(wreq),
      .addr(col0),
      .pixel({req_ch.blue_in, req_ch.green_in, req_ch.red_in}),
      .window(window)
   );

   always_comb begin
      for (int k = 0; k < KERNEL_SIDE; k++) begin
         for (int j = 0; j < KERNEL_SIDE; j++) begin
            coefs[k*KERNEL_SIDE+j] = s2_mask_ff[k*KERNEL_SIDE+j] ?
                                     coef_ff[k][COEF_W*j +: COEF_W] : '0;
            for (int c = 0; c < CH_N; c++) begin
               taps[c][k*KERNEL_SIDE+j] = window[k][j][PIX_W*c +: PIX_W];
            end
         end
      end
   end

   for (genvar c = 0; c < CH_N; c++) begin : g_lane
      rwc_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane (
         .clock(clock),
         .taps(taps[c]),
         .coefs(coefs),
         .value(lane_vals[c])
      );
   end

   rwc_out_fifo u_out (
      .clock(clock),
      .reset(reset),
      .reserve(emit),
      .push(s4_valid_ff),
      .lanes(lane_vals),
      .frame_end(s4_fe_ff),
      .room(room),
      .rsp(rsp_ch)
   );

   a_emit_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      emit |-> ##4 s4_valid_ff)
      else $error("result did not reach the output queue");

   a_out_row_bound: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= h_ff)
      else $error("output row beyond frame height");

   a_no_emit_on_dropped_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && is_drain && out_row_ff >= h_ff) |-> !emit)
      else $error("drain with nothing pending produced a result");
endmodule
`default_nettype wire

[rtl/rwc_window.sv]
// Two line stores and the 3x3 window register.
`default_nettype none
module rwc_window
   import rwc_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  win_req_type wreq,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  pixel_type pixel,
   output window_type window
);
   localparam int CW = $clog2(MAX_WIDTH);

   pixel_type mem_a [MAX_WIDTH];
   pixel_type mem_b [MAX_WIDTH];

   logic s1_valid_ff, s1_restart_ff, s1_drain_ff;
   logic [CW-1:0] s1_addr_ff;
   pixel_type s1_pix_ff, rd_a_ff, rd_b_ff;
   window_type win_ff;
   logic fwd;
   pixel_type new_col [KERNEL_SIDE];

   assign fwd = s1_valid_ff && !s1_drain_ff && (s1_addr_ff == addr);
   assign new_col[0] = rd_b_ff;
   assign new_col[1] = rd_a_ff;
   assign new_col[2] = s1_drain_ff ? '0 : s1_pix_ff;
   assign window = win_ff;

   always_ff @(posedge clock) begin
      if (fwd) begin
         rd_a_ff <= s1_pix_ff;
         rd_b_ff <= rd_a_ff;
      end else begin
         rd_a_ff <= mem_a[addr];
         rd_b_ff <= mem_b[addr];
      end
      if (s1_valid_ff && !s1_drain_ff) begin
         mem_a[s1_addr_ff] <= s1_pix_ff;
         mem_b[s1_addr_ff] <= rd_a_ff;
      end
      s1_addr_ff <= addr;
      s1_pix_ff <= pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_restart_ff <= 1'b0;
         s1_drain_ff <= 1'b0;
         win_ff <= '0;
      end else begin
         s1_valid_ff <= wreq.valid;
         s1_restart_ff <= wreq.restart;
         s1_drain_ff <= wreq.drain;
         if (wreq.clear) begin
            win_ff <= '0;
         end else if (s1_valid_ff) begin
            for (int k = 0; k < KERNEL_SIDE; k++) begin
               win_ff[k][0] <= s1_restart_ff ? '0 : win_ff[k][1];
               win_ff[k][1] <= s1_restart_ff ? '0 : win_ff[k][2];
               win_ff[k][2] <= new_col[k];
            end
         end
      end
   end
endmodule
`default_nettype wire

[rtl/rwc_lane.sv]
// One color lane: nine taps multiplied, summed, truncated and clamped.
`default_nettype none
module rwc_lane
   import rwc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic clock,
   input  tap_pix_type taps,
   input  tap_coef_type coefs,
   output logic [PIX_W-1:0] value
);
   logic signed [PROD_W-1:0] prod_ff [TAP_N];
   logic signed [SUM_W-1:0] sum_ff, sum_c;
   logic [SUM_W-1:0] shifted;

   always_ff @(posedge clock) begin
      for (int i = 0; i < TAP_N; i++) begin
         prod_ff[i] <= $signed({1'b0, taps[i]}) * $signed(coefs[i]);
      end
      sum_ff <= sum_c;
   end

   always_comb begin
      sum_c = '0;
      for (int i = 0; i < TAP_N; i++) begin
         sum_c = sum_c + SUM_W'(prod_ff[i]);
      end
   end

   assign shifted = SUM_W'(sum_ff >>> COEF_FRAC_BITS);

   always_comb begin
      if (sum_ff <= 0) begin
         value = '0;
      end else if (shifted > SUM_W'(PIXEL_MAX)) begin
         value = PIX_W'(PIXEL_MAX);
      end else begin
         value = shifted[PIX_W-1:0];
      end
   end
endmodule
`default_nettype wire

[rtl/rwc_out_fifo.sv]
// Merges the lane results into response entries and queues them with credit control.
`default_nettype none
module rwc_out_fifo
   import rwc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic reserve,
   input  logic push,
   input  lane_values_type lanes,
   input  logic frame_end,
   output logic room,
   rwc_rsp_if.source rsp
);
   localparam int PW = $clog2(OUT_DEPTH);
   localparam int NW = $clog2(OUT_DEPTH + 1);

   result_type buf_ff [OUT_DEPTH];
   result_type entry;
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] fill_ff, credit_ff;
   logic pop;

   assign entry.red = lanes[0];
   assign entry.green = lanes[1];
   assign entry.blue = lanes[2];
   assign entry.frame_end = frame_end;

   assign pop = rsp.valid && rsp.ready;
   assign room = credit_ff < NW'(OUT_DEPTH);
   assign rsp.valid = fill_ff != '0;
   assign rsp.red_out = buf_ff[rd_ptr_ff].red;
   assign rsp.green_out = buf_ff[rd_ptr_ff].green;
   assign rsp.blue_out = buf_ff[rd_ptr_ff].blue;
   assign rsp.frame_end = buf_ff[rd_ptr_ff].frame_end;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + NW'(push) - NW'(pop);
         credit_ff <= credit_ff + NW'(reserve) - NW'(pop);
      end
   end
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench of the 3x3 RGB window convolution: directed and random frames.
`default_nettype none
module tb;
   import rwc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LOW = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;
   localparam int SETTLE_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1450;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rwc_req_if req_ch();
   rwc_rsp_if rsp_ch();
   rwc_csr_if csr_ch();

   rgb_window_convolution DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state mirror
   logic [GEOM_W-1:0] frame_width_q, frame_height_q;
   logic radius_q;
   logic [CSR_DATA_W-1:0] coef_row_q [3];
   pixel_type older_row [DEF_MAX_WIDTH];
   pixel_type recent_row [DEF_MAX_WIDTH];
   pixel_type window_q [3][3];
   int col_pos, row_pos, out_pos;

   result_type filtered_pixels [$];
   int error_count = 0;
   int random_items = 0;
   bit steady = 1'b0;
   bit long_hold_due = 1'b0;
   int rsp_stall_left = 0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int active_width();
      if (frame_width_q == 0) return 1;
      return (frame_width_q > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(frame_width_q);
   endfunction

   function automatic int active_height();
      if (frame_height_q == 0) return 1;
      return (frame_height_q > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(frame_height_q);
   endfunction

   task automatic clear_frame();
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
      for (int k = 0; k < 3; k++)
         for (int j = 0; j < 3; j++)
            window_q[k][j] = '0;
   endtask

   task automatic load_defaults();
      frame_width_q = RST_FRAME_WIDTH;
      frame_height_q = RST_FRAME_HEIGHT;
      radius_q = 1'b1;
      coef_row_q[0] = '0;
      coef_row_q[1] = RST_COEF_MIDDLE;
      coef_row_q[2] = '0;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
         older_row[i] = '0;
         recent_row[i] = '0;
      end
      clear_frame();
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_FRAME_WIDTH: begin
            frame_width_q = data[GEOM_W-1:0];
            clear_frame();
         end
         REG_FRAME_HEIGHT: begin
            frame_height_q = data[GEOM_W-1:0];
            clear_frame();
         end
         REG_KERNEL_RADIUS: radius_q = data[0];
         REG_COEF_TOP: coef_row_q[0] = data;
         REG_COEF_MIDDLE: coef_row_q[1] = data;
         REG_COEF_BOTTOM: coef_row_q[2] = data;
         default: ;
      endcase
   endtask

   task automatic shift_window(input pixel_type upper, input pixel_type centre,
                               input pixel_type lower);
      for (int k = 0; k < 3; k++) begin
         window_q[k][0] = window_q[k][1];
         window_q[k][1] = window_q[k][2];
      end
      window_q[0][2] = upper;
      window_q[1][2] = centre;
      window_q[2][2] = lower;
   endtask

   task automatic push_filtered(input int w, input int h);
      int r, c, pv, cv, rr, cc;
      longint sum;
      logic [PIX_W-1:0] lane [3];
      result_type res;
      r = out_pos / w;
      c = out_pos % w;
      for (int ch = 0; ch < 3; ch++) begin
         sum = 0;
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) begin
               rr = r + k;
               cc = c + j;
               if (!radius_q && (k != 1 || j != 1)) continue;
               if (rr < 1 || rr - 1 >= h || cc < 1 || cc - 1 >= w) continue;
               pv = window_q[k][j][8*ch +: 8];
               cv = $signed(coef_row_q[k][16*j +: 16]);
               sum += longint'(pv) * longint'(cv);
            end
         if (sum <= 0) lane[ch] = '0;
         else if ((sum >>> DEF_COEF_FRAC_BITS) > PIXEL_MAX) lane[ch] = PIX_W'(PIXEL_MAX);
         else lane[ch] = PIX_W'(sum >>> DEF_COEF_FRAC_BITS);
      end
      res.red = lane[0];
      res.green = lane[1];
      res.blue = lane[2];
      res.frame_end = (out_pos + 1 == w * h);
      filtered_pixels.push_back(res);
      out_pos++;
   endtask

   task automatic predict_request(input logic kind, input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, output bit dropped);
      int w, h, idx;
      pixel_type px, up, mid;
      w = active_width();
      h = active_height();
      dropped = 1'b0;
      if (kind == KIND_PIXEL) begin
         if (row_pos >= h) clear_frame();
         px = {b, g, r};
         up = older_row[col_pos];
         mid = recent_row[col_pos];
         older_row[col_pos] = mid;
         recent_row[col_pos] = px;
         shift_window(up, mid, px);
      end else begin
         if (row_pos < h || out_pos >= w * h) begin
            dropped = 1'b1;
            return;
         end
         shift_window(older_row[col_pos], recent_row[col_pos], '0);
      end
      idx = row_pos * w + col_pos;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (idx >= w + 1 && out_pos < w * h) push_filtered(w, h);
   endtask

   task automatic send_request(input logic kind, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
      int gap;
      bit dropped;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.red_in <= r;
      req_ch.green_in <= g;
      req_ch.blue_in <= b;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(kind, r, g, b, dropped);
      if (!dropped) random_items++;
   endtask

   task automatic send_pixels(input int n);
      for (int i = 0; i < n; i++)
         send_request(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_drains(input int n);
      for (int i = 0; i < n; i++)
         send_request(KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (filtered_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_quiet();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      apply_register(index, data);
   endtask

   task automatic set_geometry(input int w, input int h);
      write_register(REG_FRAME_WIDTH,
                     CSR_DATA_W'(({$urandom, $urandom} & ~64'h7FF) | 64'(w)));
      write_register(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   function automatic logic [15:0] random_coef();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 320) - 64);
   endfunction

   task automatic test_identity_border();
      set_geometry(3, 2);
      send_drains(1);
      send_request(KIND_PIXEL, 8'h00, 8'hFF, 8'hAA);
      send_request(KIND_PIXEL, 8'hFF, 8'h00, 8'h55);
      send_request(KIND_PIXEL, 8'h80, 8'h01, 8'hFE);
      send_pixels(3);
      send_drains(6);
      write_register(REG_COEF_TOP, 48'h0100_0100_0100);
      write_register(REG_COEF_BOTTOM, 48'h0080_0080_0080);
      send_pixels(6);
      send_drains(4);
   endtask

   task automatic test_radius_rounding();
      set_geometry(2, 2);
      write_register(REG_KERNEL_RADIUS, 48'd0);
      write_register(REG_COEF_MIDDLE, 48'h0000_FF00_0000);
      send_request(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_pixels(3);
      send_drains(3);
      write_register(REG_COEF_MIDDLE, 48'h7FFF_7FFF_7FFF);
      send_pixels(4);
      send_drains(3);
      write_register(REG_KERNEL_RADIUS, 48'd1);
      write_register(REG_COEF_TOP, 48'hFFFF_FFFF_FFFF);
      write_register(REG_COEF_MIDDLE, 48'h8000_0181_0001);
      write_register(REG_COEF_BOTTOM, 48'h8000_8000_8000);
      send_pixels(4);
      send_drains(3);
   endtask

   task automatic test_restart_cases();
      write_register(REG_COEF_TOP, 48'h0040_0040_0040);
      write_register(REG_COEF_MIDDLE, 48'h0040_0080_0040);
      write_register(REG_COEF_BOTTOM, 48'h0040_0040_0040);
      set_geometry(2, 1);
      send_pixels(2);
      send_drains(1);
      send_pixels(2);
      send_drains(4);
      set_geometry(3, 3);
      send_pixels(2);
      write_register(REG_SPARE_LOW, '1);
      write_register(REG_SPARE_HIGH, '1);
      set_geometry(0, 0);
      send_pixels(1);
      send_drains(3);
   endtask

   task automatic test_extreme_geometry();
      set_geometry(2047, 1);
      send_pixels(DEF_MAX_WIDTH);
      send_drains(3);
      set_geometry(1, 2047);
      send_pixels(3);
      send_drains(1);
   endtask

   task automatic test_backpressure();
      set_geometry(8, 4);
      steady = 1'b1;
      long_hold_due = 1'b1;
      send_pixels(32);
      send_drains(9);
      steady = 1'b0;
   endtask

   task automatic test_random_frames();
      int w, h, mode, n;
      while (random_items < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
         h = $urandom_range(1, 6);
         set_geometry(w, h);
         write_register(REG_KERNEL_RADIUS, CSR_DATA_W'($urandom_range(0, 3) != 0));
         write_register(REG_COEF_TOP, {random_coef(), random_coef(), random_coef()});
         write_register(REG_COEF_MIDDLE, {random_coef(), random_coef(), random_coef()});
         write_register(REG_COEF_BOTTOM, {random_coef(), random_coef(), random_coef()});
         steady = ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 9);
         n = w * h;
         if (mode == 0) begin
            send_pixels($urandom_range(0, n - 1));
         end else if (mode == 1) begin
            send_pixels(n);
            send_drains($urandom_range(0, w));
            send_pixels(n);
            send_drains(w + 1);
         end else begin
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 19) == 0) send_drains(1);
               send_pixels(1);
            end
            send_drains(w + 1 + $urandom_range(0, 2));
         end
      end
      steady = 1'b0;
   endtask

   // response checker and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (filtered_pixels.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               result_type want;
               want = filtered_pixels.pop_front();
               if (rsp_ch.red_out !== want.red)
                  report_mismatch("red", rsp_ch.red_out, want.red);
               if (rsp_ch.green_out !== want.green)
                  report_mismatch("green", rsp_ch.green_out, want.green);
               if (rsp_ch.blue_out !== want.blue)
                  report_mismatch("blue", rsp_ch.blue_out, want.blue);
               if (rsp_ch.frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_ch.frame_end, want.frame_end);
            end
         end
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall_left = 300;
         end
         if (rsp_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left--;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left = gap_len();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_PIXEL;
      req_ch.red_in = '0;
      req_ch.green_in = '0;
      req_ch.blue_in = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_FRAME_WIDTH;
      csr_ch.data = '0;
      load_defaults();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_border();
      test_radius_rounding();
      test_restart_cases();
      test_extreme_geometry();
      test_backpressure();
      test_random_frames();
      wait_quiet();
      repeat (20) @(posedge clock);
      if (filtered_pixels.size() != 0)
         report_mismatch("responses never seen", 0, filtered_pixels.size());
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

[rgb_window_convolution.f]
rtl/rwc_pkg.sv
rtl/rwc_if.sv
rtl/rwc_window.sv
rtl/rwc_lane.sv
rtl/rwc_out_fifo.sv
rtl/rgb_window_convolution.sv
bench/tb.sv
